FILE: design/brpc_pkg.sv
// Shared types, address-map codes and constants for the banked RAM port controller.
`default_nettype none

package brpc_pkg;

  localparam int RAM_ADDR_BITS = 21;
  localparam int PORT_COUNT    = 4;
  localparam int PORT_BITS     = $clog2(PORT_COUNT);

  // Command codes; code three behaves as a peek.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_PEEK  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Page decode: address bits 12:8 must hold this value.
  localparam logic [4:0] PAGE_SEL = 5'h1A;
  localparam logic [2:0] LATCH_REGION = 3'b111;

  // Port register selects (low nibble).
  localparam logic [3:0] SEL_DATA0  = 4'h0;
  localparam logic [3:0] SEL_DATA1  = 4'h1;
  localparam logic [3:0] SEL_BASE0  = 4'h2;
  localparam logic [3:0] SEL_BASE1  = 4'h3;
  localparam logic [3:0] SEL_BASE2  = 4'h4;
  localparam logic [3:0] SEL_OFS0   = 4'h5;
  localparam logic [3:0] SEL_OFS1   = 4'h6;
  localparam logic [3:0] SEL_STEP0  = 4'h7;
  localparam logic [3:0] SEL_STEP1  = 4'h8;
  localparam logic [3:0] SEL_MODE   = 4'h9;
  localparam logic [3:0] SEL_TRIG   = 4'hA;

  // Latch region selects (low five bits).
  localparam logic [4:0] LSEL_BYTE0 = 5'h00;
  localparam logic [4:0] LSEL_BYTE1 = 5'h01;
  localparam logic [4:0] LSEL_BYTE2 = 5'h02;
  localparam logic [4:0] LSEL_BYTE3 = 5'h03;
  localparam logic [4:0] LSEL_SHIFT = 5'h04;
  localparam logic [4:0] LSEL_ROT   = 5'h05;
  localparam logic [4:0] LSEL_ID0   = 5'h1C;
  localparam logic [4:0] LSEL_ID1   = 5'h1D;
  localparam logic [4:0] LSEL_ID2   = 5'h1E;
  localparam logic [4:0] LSEL_ID3   = 5'h1F;

  localparam logic [7:0] ID_BYTE0   = 8'h00;
  localparam logic [7:0] ID_BYTE1   = 8'h00;
  localparam logic [7:0] ID_BYTE2   = 8'h10;
  localparam logic [7:0] ID_BYTE3   = 8'h51;
  localparam logic [7:0] UNMAPPED   = 8'hFF;

  // Mode register bits.
  localparam int MODE_AUTO     = 0;
  localparam int MODE_ADD_OFS  = 1;
  localparam int MODE_SIGNED   = 3;
  localparam int MODE_INC_BASE = 4;

  // Mode bits 6:5: when the offset folds into the base.
  localparam logic [1:0] FOLD_OFS_LO = 2'd1;
  localparam logic [1:0] FOLD_OFS_HI = 2'd2;
  localparam logic [1:0] FOLD_TRIG   = 2'd3;

  localparam logic [23:0] SIGNED_BIAS = 24'hFF0000;

  typedef struct packed {
    logic [23:0] base;
    logic [15:0] offset;
    logic [15:0] step;
    logic [6:0]  mode;
  } port_t;

  typedef port_t [PORT_COUNT-1:0] port_arr_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  shift_amt;
    logic [3:0]  rot_amt;
  } latch_t;

  typedef struct packed {
    logic                     rd;
    logic                     wr;
    logic [RAM_ADDR_BITS-1:0] addr;
    logic [7:0]               wdata;
  } ram_req_t;

  typedef struct packed {
    logic       from_ram;
    logic [7:0] value;
  } rd_res_t;

endpackage

`default_nettype wire

FILE: design/brpc_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module brpc_ram #(
  parameter int ADDR_BITS = 21,
  parameter int DATA_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [DATA_BITS-1:0] wdata,
  output logic      [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/brpc_exec.sv
// Address decode, register update and RAM request for one bus beat.
`default_nettype none

module brpc_exec import brpc_pkg::*; (
  input  wire logic [1:0]  cmd,
  input  wire logic [12:0] addr,
  input  wire logic [7:0]  wdata,
  input  wire port_arr_t   ports,
  input  wire latch_t      latch,
  output port_arr_t        ports_nxt,
  output latch_t           latch_nxt,
  output ram_req_t         ram_req,
  output rd_res_t          rd_res
);

  logic [PORT_BITS-1:0] p;
  port_t                cur;
  port_t                stepped;
  logic [23:0]          folded;
  logic [23:0]          ram_full;
  logic                 is_write;
  logic                 side;
  logic                 port_hit;
  logic                 latch_hit;
  logic                 data_sel;
  logic [1:0]           fold;
  logic [4:0]           byte_pos;
  logic [3:0]           amt;
  logic [4:0]           right_cnt;

  assign p         = addr[4 +: PORT_BITS];
  assign cur       = ports[p];
  assign is_write  = (cmd == CMD_WRITE);
  assign side      = (cmd == CMD_READ);
  assign port_hit  = (addr[12:8] == PAGE_SEL) && !addr[7];
  assign latch_hit = (addr[12:8] == PAGE_SEL) && (addr[7:5] == LATCH_REGION);
  assign data_sel  = port_hit && ((addr[3:0] == SEL_DATA0) || (addr[3:0] == SEL_DATA1));
  assign fold      = cur.mode[6:5];
  assign byte_pos  = {addr[1:0], 3'b000};
  assign amt       = wdata[3:0];
  assign right_cnt = 5'd16 - {1'b0, amt};

  // Base plus offset, with the signed bias when enabled.
  assign folded   = cur.base + {8'h00, cur.offset}
                  + (cur.mode[MODE_SIGNED] ? SIGNED_BIAS : 24'h000000);
  assign ram_full = cur.mode[MODE_ADD_OFS] ? folded : cur.base;

  always_comb begin
    stepped = cur;
    if (cur.mode[MODE_AUTO]) begin
      if (cur.mode[MODE_INC_BASE]) begin
        stepped.base = cur.base + {8'h00, cur.step};
      end else begin
        stepped.offset = cur.offset + cur.step;
      end
    end
  end

  always_comb begin
    ram_req.rd    = data_sel && !is_write;
    ram_req.wr    = data_sel && is_write;
    ram_req.addr  = ram_full[RAM_ADDR_BITS-1:0];
    ram_req.wdata = wdata;
  end

  // State updates.
  always_comb begin
    ports_nxt = ports;
    latch_nxt = latch;
    if (port_hit && data_sel && (is_write || side)) begin
      ports_nxt[p] = stepped;
    end
    if (port_hit && is_write) begin
      unique case (addr[3:0])
        SEL_BASE0: ports_nxt[p].base[7:0]   = wdata;
        SEL_BASE1: ports_nxt[p].base[15:8]  = wdata;
        SEL_BASE2: ports_nxt[p].base[23:16] = wdata;
        SEL_OFS0: begin
          ports_nxt[p].offset[7:0] = wdata;
          if (fold == FOLD_OFS_LO) begin
            ports_nxt[p].base = cur.base + {8'h00, cur.offset[15:8], wdata}
                              + (cur.mode[MODE_SIGNED] ? SIGNED_BIAS : 24'h000000);
          end
        end
        SEL_OFS1: begin
          ports_nxt[p].offset[15:8] = wdata;
          if (fold == FOLD_OFS_HI) begin
            ports_nxt[p].base = cur.base + {8'h00, wdata, cur.offset[7:0]}
                              + (cur.mode[MODE_SIGNED] ? SIGNED_BIAS : 24'h000000);
          end
        end
        SEL_STEP0: ports_nxt[p].step[7:0]  = wdata;
        SEL_STEP1: ports_nxt[p].step[15:8] = wdata;
        SEL_MODE:  ports_nxt[p].mode       = wdata[6:0];
        SEL_TRIG: begin
          if (fold == FOLD_TRIG) begin
            ports_nxt[p].base = folded;
          end
        end
        default: ;
      endcase
    end
    if (latch_hit && is_write) begin
      unique case (addr[4:0])
        LSEL_BYTE0, LSEL_BYTE1, LSEL_BYTE2, LSEL_BYTE3: begin
          latch_nxt.value[byte_pos +: 8] = wdata;
        end
        LSEL_SHIFT: begin
          latch_nxt.shift_amt = amt;
          if (amt[3]) begin
            latch_nxt.value = latch.value >> right_cnt;
          end else if (amt != 4'd0) begin
            latch_nxt.value = latch.value << amt;
          end
        end
        LSEL_ROT: begin
          latch_nxt.rot_amt = amt;
          if (amt[3]) begin
            latch_nxt.value = (latch.value >> right_cnt)
                            | (latch.value << (6'd32 - {1'b0, right_cnt}));
          end else if (amt != 4'd0) begin
            latch_nxt.value = (latch.value << amt)
                            | (latch.value >> (6'd32 - {2'b00, amt}));
          end
        end
        default: ;
      endcase
    end
  end

  // Read value; RAM data is merged one stage later.
  always_comb begin
    rd_res.from_ram = 1'b0;
    rd_res.value    = UNMAPPED;
    if (is_write) begin
      rd_res.value = 8'h00;
    end else if (port_hit) begin
      unique case (addr[3:0])
        SEL_DATA0, SEL_DATA1: rd_res.from_ram = 1'b1;
        SEL_BASE0: rd_res.value = cur.base[7:0];
        SEL_BASE1: rd_res.value = cur.base[15:8];
        SEL_BASE2: rd_res.value = cur.base[23:16];
        SEL_OFS0:  rd_res.value = cur.offset[7:0];
        SEL_OFS1:  rd_res.value = cur.offset[15:8];
        SEL_STEP0: rd_res.value = cur.step[7:0];
        SEL_STEP1: rd_res.value = cur.step[15:8];
        SEL_MODE:  rd_res.value = {1'b0, cur.mode};
        default:   rd_res.value = UNMAPPED;
      endcase
    end else if (latch_hit) begin
      unique case (addr[4:0])
        LSEL_BYTE0, LSEL_BYTE1, LSEL_BYTE2, LSEL_BYTE3: begin
          rd_res.value = latch.value[byte_pos +: 8];
        end
        LSEL_SHIFT: rd_res.value = {4'h0, latch.shift_amt};
        LSEL_ROT:   rd_res.value = {4'h0, latch.rot_amt};
        LSEL_ID0:   rd_res.value = ID_BYTE0;
        LSEL_ID1:   rd_res.value = ID_BYTE1;
        LSEL_ID2:   rd_res.value = ID_BYTE2;
        LSEL_ID3:   rd_res.value = ID_BYTE3;
        default:    rd_res.value = UNMAPPED;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/banked_ram_port_controller_core.sv
// Top level of the banked RAM port controller: pipeline, state registers and card RAM.
`default_nettype none

// Bus-side controller with four windowed ports into a 2 MiB byte RAM, a 32-bit
// shift/rotate latch and ID bytes, all in one 256-byte page of the 8 KiB I/O
// space. Each bus beat carries a command (read, peek, write), a 13-bit address
// and a write byte, and returns exactly one read byte (zero for writes). The
// block takes one beat per cycle while in_stall is low; out_stall and the RAM
// clearing sweep hold it. A beat passes the input register, where the address
// is decoded, the port registers are updated and the RAM is accessed, and then
// the RAM return stage, while the RAM read data comes back, before its result
// reaches the output register. The receiver can take it at the next edge. The
// single RAM port (one access per cycle) sets the rate. After reset the block sweeps
// the RAM to zero, one byte per cycle; in_stall stays high for the whole sweep.
module banked_ram_port_controller_core import brpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [12:0] in_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_read_data
);

  // Input register stage.
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_cmd_r;
  logic [12:0] s1_addr_r;
  logic [7:0]  s1_wdata_r;

  // RAM return stage.
  logic        s2_valid_r, s2_valid_nxt;
  logic        s2_from_ram_r;
  logic [7:0]  s2_data_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_read_data_r;

  // Architectural state.
  port_arr_t   ports_r;
  latch_t      latch_r;
  port_arr_t   ports_nxt;
  latch_t      latch_nxt;

  // RAM clearing sweep.
  logic                     clr_busy_r;
  logic [RAM_ADDR_BITS-1:0] clr_addr_r;

  ram_req_t    req;
  rd_res_t     res;
  logic        ram_rd, ram_wr;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  logic        out_free, s2_free, s1_free;
  logic        s2_move, s1_move, in_accept;

  // Flow control: each stage advances when the stage after it is empty or moving.
  assign out_free  = !out_valid_r || !out_stall;
  assign s2_move   = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || out_free;
  assign s1_move   = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s2_free;
  assign in_stall  = clr_busy_r || !s1_free;
  assign in_accept = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;

  brpc_exec u_exec (
    .cmd       (s1_cmd_r),
    .addr      (s1_addr_r),
    .wdata     (s1_wdata_r),
    .ports     (ports_r),
    .latch     (latch_r),
    .ports_nxt (ports_nxt),
    .latch_nxt (latch_nxt),
    .ram_req   (req),
    .rd_res    (res)
  );

  // The sweep owns the RAM port until it finishes; the pipeline is empty then.
  always_comb begin
    if (clr_busy_r) begin
      ram_rd    = 1'b0;
      ram_wr    = 1'b1;
      ram_addr  = clr_addr_r;
      ram_wdata = 8'h00;
    end else begin
      ram_rd    = req.rd && s1_move;
      ram_wr    = req.wr && s1_move;
      ram_addr  = req.addr;
      ram_wdata = req.wdata;
    end
  end

  brpc_ram #(
    .ADDR_BITS (RAM_ADDR_BITS),
    .DATA_BITS (8)
  ) u_ram (
    .clk   (clk),
    .rd_en (ram_rd),
    .wr_en (ram_wr),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt  = in_accept || (s1_valid_r && !s2_free);
    s2_valid_nxt  = s1_move || (s2_valid_r && !out_free);
    out_valid_nxt = s2_move || (out_valid_r && out_stall);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      ports_r     <= '0;
      latch_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        // Drop the busy flag once the last byte is written.
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      // Commit the port and latch updates as the beat leaves the input register.
      if (s1_move) begin
        ports_r <= ports_nxt;
        latch_r <= latch_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= in_command;
      s1_addr_r  <= in_address;
      s1_wdata_r <= in_write_data;
    end
    if (s1_move) begin
      s2_from_ram_r <= res.from_ram;
      s2_data_r     <= res.value;
    end
    // Merge the RAM byte here; it holds until the next RAM read, which cannot
    // issue while this stage is still full.
    if (s2_move) begin
      out_read_data_r <= s2_from_ram_r ? ram_rdata : s2_data_r;
    end
  end

`ifndef NO_ASSERTIONS
  // The pipeline stays empty while the sweep owns the RAM.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!s1_valid_r && !s2_valid_r))
    else $error("beat in flight during RAM clearing sweep");

  // A waiting RAM byte is not overwritten before it reaches the output.
  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_from_ram_r && !s2_move) |=> $stable(ram_rdata))
    else $error("RAM read data changed while its beat waited");

  // A write beat carries a zero result into the next stage.
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (s1_cmd_r == CMD_WRITE)) |=>
      (s2_valid_r && !s2_from_ram_r && (s2_data_r == 8'h00)))
    else $error("write beat produced a nonzero result");
`endif

endmodule

`default_nettype wire
